// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk, quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in every cycle.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/wpa_pkg.sv =====
package wpa_pkg;

	localparam int CHANNELS_DEF   = 32;
	localparam int SAMPLES_DEF    = 40;
	localparam int PERIOD_NS_DEF  = 8;

	// samples averaged for the baseline
	localparam int BASE_COUNT = 5;

	localparam int CH_W     = 5;
	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 64;
	localparam int IDX_W    = 6;
	localparam int BASE_W   = 19;
	localparam int RUN_W    = 22;
	localparam int AMP_W    = 19;
	localparam int PT_W     = 9;
	localparam int INT_W    = 28;

	// channel totals at the end of a waveform
	typedef struct packed {
		logic [BASE_W-1:0]   baseline_sum;
		logic [RUN_W-1:0]    running_sum;
		logic [SAMPLE_W-1:0] min_sample;
		logic [IDX_W-1:0]    min_index;
	} wave_sum_t;

endpackage

// ===== rtl/core/wpa_chan_state.sv =====
module wpa_chan_state #(
	parameter int CHANNELS  = wpa_pkg::CHANNELS_DEF,
	parameter int SAMPLES   = wpa_pkg::SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd_en,
	input  logic [wpa_pkg::CH_W-1:0]      ch,
	input  logic [wpa_pkg::SAMPLE_W-1:0]  sample,
	output wpa_pkg::wave_sum_t            fin,
	output logic                          last
);
	import wpa_pkg::*;

	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [IDX_W-1:0]    idx_q  [CHANNELS];
	logic [BASE_W-1:0]   base_q [CHANNELS];
	logic [RUN_W-1:0]    run_q  [CHANNELS];
	logic [SAMPLE_W-1:0] min_q  [CHANNELS];
	logic [IDX_W-1:0]    mi_q   [CHANNELS];

	logic [CH_AW-1:0]    sel;
	logic [IDX_W-1:0]    cur_idx;
	logic [BASE_W-1:0]   cur_base;
	logic [RUN_W-1:0]    cur_run;
	logic [SAMPLE_W-1:0] cur_min;
	logic [IDX_W-1:0]    cur_mi;
	logic                take_min;

	assign sel      = CH_AW'(ch);
	assign cur_idx  = idx_q[sel];
	assign cur_base = base_q[sel];
	assign cur_run  = run_q[sel];
	assign cur_min  = min_q[sel];
	assign cur_mi   = mi_q[sel];

	// first sample always loads the minimum; ties keep the earlier index
	assign take_min = (cur_idx == '0) || (sample < cur_min);
	assign last     = cur_idx >= IDX_W'(SAMPLES - 1);

	always_comb begin
		fin.baseline_sum = (cur_idx < IDX_W'(BASE_COUNT)) ? cur_base + BASE_W'(sample)
		                                                  : cur_base;
		fin.running_sum  = cur_run + RUN_W'(sample);
		fin.min_sample   = take_min ? sample : cur_min;
		fin.min_index    = take_min ? cur_idx : cur_mi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				idx_q[i]  <= '0;
				base_q[i] <= '0;
				run_q[i]  <= '0;
				min_q[i]  <= '1;
				mi_q[i]   <= '0;
			end
		end else if (upd_en) begin
			if (last) begin
				idx_q[sel]  <= '0;
				base_q[sel] <= '0;
				run_q[sel]  <= '0;
				min_q[sel]  <= '1;
				mi_q[sel]   <= '0;
			end else begin
				idx_q[sel]  <= cur_idx + IDX_W'(1);
				base_q[sel] <= fin.baseline_sum;
				run_q[sel]  <= fin.running_sum;
				min_q[sel]  <= fin.min_sample;
				mi_q[sel]   <= fin.min_index;
			end
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_idx_in_range, upd_en, cur_idx < IDX_W'(SAMPLES))

endmodule

// ===== rtl/core/wpa_result_calc.sv =====
module wpa_result_calc #(
	parameter int SAMPLES   = wpa_pkg::SAMPLES_DEF,
	parameter int PERIOD_NS = wpa_pkg::PERIOD_NS_DEF
) (
	input  wpa_pkg::wave_sum_t                fin,
	output logic [wpa_pkg::AMP_W-1:0]         amplitude,
	output logic [wpa_pkg::PT_W-1:0]          peak_time,
	output logic signed [wpa_pkg::INT_W-1:0]  integral
);
	import wpa_pkg::*;

	// folded constants: (SAMPLES*base - 5*run) * period
	localparam logic [11:0] K_BASE = 12'(SAMPLES * PERIOD_NS);
	localparam logic [8:0]  K_RUN  = 9'(BASE_COUNT * PERIOD_NS);
	localparam logic [6:0]  PER7   = 7'(PERIOD_NS);
	localparam logic signed [32:0] INT_HI = 33'sd134217727;
	localparam logic signed [32:0] INT_LO = -33'sd134217728;

	logic [BASE_W-1:0]    min5;
	logic [30:0]          prod_base;
	logic [30:0]          prod_run;
	logic signed [32:0]   diff;
	logic [12:0]          pt_full;

	assign min5 = BASE_W'({fin.min_sample, 2'b00}) + BASE_W'(fin.min_sample);
	assign amplitude = (fin.baseline_sum >= min5) ? AMP_W'(fin.baseline_sum - min5) : '0;

	assign pt_full   = 13'(fin.min_index) * 13'(PER7);
	assign peak_time = (pt_full > 13'd511) ? PT_W'(9'h1FF) : PT_W'(pt_full);

	assign prod_base = 31'(fin.baseline_sum) * 31'(K_BASE);
	assign prod_run  = 31'(fin.running_sum) * 31'(K_RUN);
	assign diff      = $signed({2'b00, prod_base}) - $signed({2'b00, prod_run});

	always_comb begin
		if (diff > INT_HI)
			integral = INT_W'(INT_HI);
		else if (diff < INT_LO)
			integral = INT_W'(INT_LO);
		else
			integral = INT_W'(diff);
	end

endmodule

// ===== rtl/core/waveform_pulse_analyzer_core.sv =====
// Pulse analyzer for channel-tagged ADC samples.
// Sample channel: sample_valid/sample_ready carry channel, sample and event_time.
// Samples of one channel arrive in waveform order; channels may interleave freely.
// A beat whose channel is at or above CHANNELS is taken and dropped.
// Result channel: result_valid/result_ready carry one beat per completed waveform
// (peak amplitude and integral in fifths of a count, first-peak time, timestamp).
// Throughput: one sample beat per cycle, same channel back to back included,
// except while sample_ready is low (see below). A waveform's last sample, once
// accepted, moves through the staging register and the result register.
// Per-channel state sits in flip-flops; its combinational read-modify-write
// sets the timing path.
// Reset puts every channel at the start of a new waveform at once, no sweep.
// When the receiver stalls, the output register plus one staged result hold
// up to two finished waveforms; samples keep flowing until a waveform-ending
// sample finds both full, and only then sample_ready drops.
module waveform_pulse_analyzer_core #(
	parameter int CHANNELS  = wpa_pkg::CHANNELS_DEF,
	parameter int SAMPLES   = wpa_pkg::SAMPLES_DEF,
	parameter int PERIOD_NS = wpa_pkg::PERIOD_NS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic [wpa_pkg::CH_W-1:0]           channel,
	input  logic [wpa_pkg::SAMPLE_W-1:0]       sample,
	input  logic [wpa_pkg::TIME_W-1:0]         event_time,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [wpa_pkg::CH_W-1:0]           result_channel,
	output logic [wpa_pkg::AMP_W-1:0]          amplitude_fifths,
	output logic [wpa_pkg::PT_W-1:0]           peak_time_ns,
	output logic signed [wpa_pkg::INT_W-1:0]   integral_fifths,
	output logic [wpa_pkg::TIME_W-1:0]         result_time
);
	import wpa_pkg::*;

	logic                ch_ok;
	logic                in_take;

	logic                valid_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [TIME_W-1:0]   time_s1;

	wave_sum_t           fin;
	logic                last_s1;
	logic                upd_en;

	logic                valid_s2;
	logic [CH_W-1:0]     ch_s2;
	logic [TIME_W-1:0]   time_s2;
	wave_sum_t           fin_s2;
	logic                s2_ready;

	logic                out_free;
	logic                res_valid_q;
	logic [CH_W-1:0]     res_ch_q;
	logic [AMP_W-1:0]    amp_q;
	logic [PT_W-1:0]     pt_q;
	logic signed [INT_W-1:0] int_q;
	logic [TIME_W-1:0]   res_time_q;

	logic [AMP_W-1:0]        amp_c;
	logic [PT_W-1:0]         pt_c;
	logic signed [INT_W-1:0] int_c;

	assign out_free     = !res_valid_q || result_ready;
	assign s2_ready     = !valid_s2 || out_free;
	assign upd_en       = valid_s1 && (!last_s1 || s2_ready);
	assign sample_ready = !valid_s1 || upd_en;
	assign in_take      = sample_valid && sample_ready;
	assign ch_ok        = {2'b00, channel} < 7'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid && ch_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1     <= channel;
			sample_s1 <= sample;
			time_s1   <= event_time;
		end
	end

	wpa_chan_state #(
		.CHANNELS (CHANNELS),
		.SAMPLES  (SAMPLES)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (upd_en),
		.ch     (ch_s1),
		.sample (sample_s1),
		.fin    (fin),
		.last   (last_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= upd_en && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && upd_en && last_s1) begin
			ch_s2   <= ch_s1;
			time_s2 <= time_s1;
			fin_s2  <= fin;
		end
	end

	wpa_result_calc #(
		.SAMPLES   (SAMPLES),
		.PERIOD_NS (PERIOD_NS)
	) u_calc (
		.fin       (fin_s2),
		.amplitude (amp_c),
		.peak_time (pt_c),
		.integral  (int_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			res_ch_q   <= ch_s2;
			amp_q      <= amp_c;
			pt_q       <= pt_c;
			int_q      <= int_c;
			res_time_q <= time_s2;
		end
	end

	assign result_valid     = res_valid_q;
	assign result_channel   = res_ch_q;
	assign amplitude_fifths = amp_q;
	assign peak_time_ns     = pt_q;
	assign integral_fifths  = int_q;
	assign result_time      = res_time_q;

`include "assert_macros.svh"

	// dropped channels never reach the state update
	`ASSERT_NEXT(a_drop_bad_ch, in_take && !ch_ok, !valid_s1)
	// a finished waveform waiting on a full result path blocks new beats
	`ASSERT_IMPLIES(a_hold_on_full, valid_s1 && last_s1 && !s2_ready, !sample_ready)
	// a staged result moves on whenever the output register is free
	`ASSERT_NEXT(a_s2_moves, valid_s2 && out_free, res_valid_q)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import wpa_pkg::*;

	localparam int NCH      = CHANNELS_DEF;
	localparam int WAVE_LEN = SAMPLES_DEF;
	localparam int PERIOD   = PERIOD_NS_DEF;
	localparam longint PT_MAX = (longint'(1) << PT_W) - 1;
	localparam longint INT_HI = (longint'(1) << (INT_W - 1)) - 1;
	localparam longint INT_LO = -(longint'(1) << (INT_W - 1));

	localparam int DIR_ROWS    = 11;
	localparam int NO_DIP      = -1;
	localparam int RAND_ITEMS  = 1160;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 12;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [AMP_W-1:0]  amp;
		logic [PT_W-1:0]   pt;
		logic [INT_W-1:0]  integ;
		logic [TIME_W-1:0] tstamp;
	} pulse_res_t;

	// one directed waveform: five baseline samples, body samples, up to two dips
	typedef struct {
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] base_lvl;
		logic [SAMPLE_W-1:0] body_lvl;
		logic [SAMPLE_W-1:0] dip_lvl;
		int                  dip_a;
		int                  dip_b;
		logic [TIME_W-1:0]   last_ts;
		bit                  typed;
		pulse_res_t          want;
	} wave_row_t;

	typedef enum {RX_OPEN, RX_RANDOM, RX_HOLD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	logic [CH_W-1:0] channel;
	logic [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0] event_time;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [CH_W-1:0] result_channel;
	logic [AMP_W-1:0] amplitude_fifths;
	logic [PT_W-1:0] peak_time_ns;
	logic signed [INT_W-1:0] integral_fifths;
	logic [TIME_W-1:0] result_time;

	waveform_pulse_analyzer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.channel(channel),
		.sample(sample),
		.event_time(event_time),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_channel(result_channel),
		.amplitude_fifths(amplitude_fifths),
		.peak_time_ns(peak_time_ns),
		.integral_fifths(integral_fifths),
		.result_time(result_time)
	);

	always #10 clk = ~clk;

	// per-channel shadow state
	logic [IDX_W-1:0]    wave_pos [NCH];
	logic [BASE_W-1:0]   base_acc [NCH];
	logic [RUN_W-1:0]    sum_acc  [NCH];
	logic [SAMPLE_W-1:0] low_val  [NCH];
	logic [IDX_W-1:0]    low_pos  [NCH];

	pulse_res_t expected_pulses[$];
	wave_row_t  wave_tab[DIR_ROWS];
	int mismatches = 0;
	int burst_left;
	int idle_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;

	function automatic void clear_shadow(input int ch);
		wave_pos[ch] = '0;
		base_acc[ch] = '0;
		sum_acc[ch]  = '0;
		low_val[ch]  = '1;
		low_pos[ch]  = '0;
	endfunction

	// Folds one sample into the channel's shadow state; returns 1 with the
	// pulse summary when the sample closes a waveform.
	function automatic bit fold_sample(input logic [CH_W-1:0] ch,
			input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] ts,
			output pulse_res_t res);
		int pos;
		longint amp_l;
		longint pt_l;
		longint integ_l;
		res = '0;
		if (int'(ch) >= NCH)
			return 1'b0;
		pos = int'(wave_pos[ch]);
		if (pos < BASE_COUNT)
			base_acc[ch] = base_acc[ch] + BASE_W'(s);
		sum_acc[ch] = sum_acc[ch] + RUN_W'(s);
		// strict compare: first occurrence of the minimum wins
		if (pos == 0 || s < low_val[ch]) begin
			low_val[ch] = s;
			low_pos[ch] = pos[IDX_W-1:0];
		end
		if (pos + 1 < WAVE_LEN) begin
			wave_pos[ch] = wave_pos[ch] + IDX_W'(1);
			return 1'b0;
		end
		amp_l = longint'(base_acc[ch]) - BASE_COUNT * longint'(low_val[ch]);
		if (amp_l < 0)
			amp_l = 0;
		pt_l = longint'(low_pos[ch]) * PERIOD;
		if (pt_l > PT_MAX)
			pt_l = PT_MAX;
		integ_l = (WAVE_LEN * longint'(base_acc[ch]) - BASE_COUNT * longint'(sum_acc[ch]))
			* PERIOD;
		if (integ_l > INT_HI)
			integ_l = INT_HI;
		if (integ_l < INT_LO)
			integ_l = INT_LO;
		res.ch     = ch;
		res.amp    = amp_l[AMP_W-1:0];
		res.pt     = pt_l[PT_W-1:0];
		res.integ  = integ_l[INT_W-1:0];
		res.tstamp = ts;
		clear_shadow(int'(ch));
		return 1'b1;
	endfunction

	// Sends one sample beat with bursty pacing; books any pulse it closes.
	task automatic push_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] s,
			input logic [TIME_W-1:0] ts, input bit typed, input pulse_res_t typed_res);
		int gap;
		pulse_res_t got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		channel      <= ch;
		sample       <= s;
		event_time   <= ts;
		do @(posedge clk); while (!sample_ready);
		burst_left--;
		if (fold_sample(ch, s, ts, got))
			expected_pulses.push_back(typed ? typed_res : got);
	endtask

	// Holds the sender off until every booked pulse has been delivered.
	task automatic drain_pulses();
		sample_valid <= 1'b0;
		do @(posedge clk); while (expected_pulses.size() != 0);
		burst_left = 0;
	endtask

	task automatic take_pulse();
		pulse_res_t want;
		if (expected_pulses.size() == 0) begin
			$error("unexpected result beat: channel %0d", result_channel);
			mismatches++;
		end else begin
			want = expected_pulses.pop_front();
			if (result_channel !== want.ch) begin
				$error("result_channel: expected %0d, got %0d", want.ch, result_channel);
				mismatches++;
			end
			if (amplitude_fifths !== want.amp) begin
				$error("amplitude_fifths: expected %0d, got %0d", want.amp,
					amplitude_fifths);
				mismatches++;
			end
			if (peak_time_ns !== want.pt) begin
				$error("peak_time_ns: expected %0d, got %0d", want.pt, peak_time_ns);
				mismatches++;
			end
			if (integral_fifths !== want.integ) begin
				$error("integral_fifths: expected %0d, got %0d", $signed(want.integ),
					integral_fifths);
				mismatches++;
			end
			if (result_time !== want.tstamp) begin
				$error("result_time: expected %h, got %h", want.tstamp, result_time);
				mismatches++;
			end
		end
	endtask

	// receiver: open stretches, random stalls, and solid holds
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			take_pulse();
		if (rx_left == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					rx_mode = RX_OPEN;
					rx_left = $urandom_range(10, 60);
				end
				1: begin
					rx_mode = RX_RANDOM;
					rx_left = $urandom_range(20, 80);
				end
				default: begin
					rx_mode = RX_HOLD;
					rx_left = $urandom_range(1, 40);
				end
			endcase
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   result_ready <= 1'b1;
			RX_RANDOM: result_ready <= ($urandom_range(0, 99) < 60);
			default:   result_ready <= 1'b0;
		endcase
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int v;
		int act_lo;
		int act_n;
		int lvl;
		int pick;
		logic [CH_W-1:0] ch;
		logic [SAMPLE_W-1:0] s;
		pulse_res_t none_res;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		channel      = '0;
		sample       = '0;
		event_time   = '0;
		burst_left   = 0;
		none_res     = '0;
		for (int c = 0; c < NCH; c++)
			clear_shadow(c);

		// ch, baseline, body, dip, dip index a/b, last timestamp, typed, expected
		wave_tab[0]  = '{5'd0, 16'd0, 16'd0, 16'd0, 0, NO_DIP, 64'd0, 1'b1,
			'{5'd0, 19'd0, 9'd0, 28'd0, 64'd0}};
		wave_tab[1]  = '{5'd31, 16'hFFFF, 16'hFFFF, 16'd0, WAVE_LEN - 1, NO_DIP, '1, 1'b1,
			'{5'd31, 19'd327675, 9'd312, 28'd2621400, 64'hFFFF_FFFF_FFFF_FFFF}};
		wave_tab[2]  = '{5'd7, 16'hFFFF, 16'd0, 16'd0, NO_DIP, NO_DIP,
			64'h0123_4567_89AB_CDEF, 1'b1,
			'{5'd7, 19'd327675, 9'd40, 28'd91749000, 64'h0123_4567_89AB_CDEF}};
		wave_tab[3]  = '{5'd8, 16'd0, 16'hFFFF, 16'd0, NO_DIP, NO_DIP,
			64'hFEDC_BA98_7654_3210, 1'b1,
			'{5'd8, 19'd0, 9'd0, -28'sd91749000, 64'hFEDC_BA98_7654_3210}};
		wave_tab[4]  = '{5'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_DIP, NO_DIP,
			64'h8000_0000_0000_0001, 1'b1,
			'{5'd5, 19'd0, 9'd0, 28'd0, 64'h8000_0000_0000_0001}};
		// tied minima, dip inside baseline, first-sample loads, bit patterns
		wave_tab[5]  = '{5'd3, 16'd500, 16'd500, 16'd100, 10, 30,
			64'h5555_5555_5555_5555, 1'b0, '0};
		wave_tab[6]  = '{5'd9, 16'hFFFF, 16'hFFFF, 16'd0, 2, NO_DIP, 64'd1234, 1'b0, '0};
		wave_tab[7]  = '{5'd10, 16'd40000, 16'd30000, 16'd50000, 0, NO_DIP, 64'd99,
			1'b0, '0};
		wave_tab[8]  = '{5'd11, 16'd2000, 16'd3000, 16'd100, 0, 20, 64'd7, 1'b0, '0};
		wave_tab[9]  = '{5'd3, 16'h5555, 16'hAAAA, 16'h0F0F, WAVE_LEN - 1, NO_DIP,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0};
		wave_tab[10] = '{5'd16, 16'hAAAA, 16'h5555, 16'hFFFF, 4, NO_DIP, 64'd42, 1'b0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (wave_tab[r]) begin
			for (int i = 0; i < WAVE_LEN; i++) begin
				if (i == wave_tab[r].dip_a || i == wave_tab[r].dip_b)
					s = wave_tab[r].dip_lvl;
				else if (i < BASE_COUNT)
					s = wave_tab[r].base_lvl;
				else
					s = wave_tab[r].body_lvl;
				push_sample(wave_tab[r].ch, s, wave_tab[r].last_ts - (WAVE_LEN - 1 - i),
					wave_tab[r].typed, wave_tab[r].want);
			end
		end

		act_lo = 0;
		act_n  = 1;
		lvl    = 0;
		n = 0;
		while (n < RAND_ITEMS) begin
			// most beats go to a few channels so waveforms complete
			if (n % 200 == 0) begin
				act_lo = $urandom_range(0, NCH - 1);
				act_n  = $urandom_range(1, 4);
				lvl    = $urandom_range(0, 65535);
			end
			if (n == RAND_ITEMS / 2)
				drain_pulses();
			if ($urandom_range(0, 99) < 85)
				ch = CH_W'((act_lo + $urandom_range(0, act_n - 1)) % NCH);
			else
				ch = CH_W'($urandom_range(0, NCH - 1));
			pick = $urandom_range(0, 99);
			if (pick < 50)
				v = lvl + $urandom_range(0, 30) - 15;
			else if (pick < 75)
				v = lvl - $urandom_range(0, 20000);
			else if (pick < 85)
				case ($urandom_range(0, 2))
					0: v = 0;
					1: v = 65535;
					default: v = lvl;
				endcase
			else
				v = $urandom_range(0, 65535);
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			s = v[SAMPLE_W-1:0];
			push_sample(ch, s, {$urandom, $urandom}, 1'b0, none_res);
			n++;
		end
		sample_valid <= 1'b0;

		while (expected_pulses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_pulses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== waveform_pulse_analyzer_core.f =====
+incdir+rtl/core
rtl/core/wpa_pkg.sv
rtl/core/wpa_chan_state.sv
rtl/core/wpa_result_calc.sv
rtl/core/waveform_pulse_analyzer_core.sv
test/tb_top.sv
